// ----- design/drt_pkg.sv -----
package drt_pkg;

  localparam int unsigned COORD_W = 15;
  localparam int unsigned LIST_CNT_W = 7;

  // configuration register select (byte address bit 2)
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] WIDTH_RESET = 15'd1024;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 15'd768;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_DAMAGE_ALL = 2'd1,
    ACT_MERGE = 2'd2,
    ACT_DRAIN = 2'd3
  } action_e;

  // classified work for the back end
  typedef enum logic [2:0] {
    CMD_REPORT,
    CMD_APPEND,
    CMD_SET,
    CMD_MERGE,
    CMD_DRAIN
  } cmd_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_EXEC,
    B_COL_RD,
    B_COL_ACC,
    B_COL_WR,
    B_M_RDI,
    B_M_LDI,
    B_M_RDJ,
    B_M_TST,
    B_M_WI,
    B_M_WJ,
    B_D_RD,
    B_D_OUT,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_t;

  typedef struct packed {
    cmd_e  op;
    rect_t rect;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]    out_x;
    logic [COORD_W-1:0]    out_y;
    logic [COORD_W-1:0]    out_w;
    logic [COORD_W-1:0]    out_h;
    logic                  rect_valid;
    logic                  last;
    logic [LIST_CNT_W-1:0] list_count;
  } out_item_t;

endpackage

// ----- design/drt_chan_if.sv -----
interface drt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- design/drt_ram.sv -----
module drt_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/drt_front.sv -----
module drt_front import drt_pkg::*; (
  drt_chan_if.sink           in_i,
  input  logic [COORD_W-1:0] screen_w_i,
  input  logic [COORD_W-1:0] screen_h_i,
  input  logic               full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  in_item_t           req;
  logic signed [16:0] x_lo, y_lo, x_hi, y_hi, x_end, y_end, sw, sh;
  logic               keep;

  assign req = in_i.payload;
  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i;

  // clip the request rectangle to the screen
  always_comb begin
    sw = {2'b00, screen_w_i};
    sh = {2'b00, screen_h_i};
    x_end = 17'(req.rect_x) + 17'(req.rect_w);
    y_end = 17'(req.rect_y) + 17'(req.rect_h);
    x_lo = req.rect_x[15] ? 17'sd0 : 17'(req.rect_x);
    y_lo = req.rect_y[15] ? 17'sd0 : 17'(req.rect_y);
    x_hi = (x_end < sw) ? x_end : sw;
    y_hi = (y_end < sh) ? y_end : sh;
    keep = (req.rect_w > 16'sd0) && (req.rect_h > 16'sd0) && (x_hi > x_lo) && (y_hi > y_lo);
  end

  // classify the request
  always_comb begin
    cmd_o.rect.x = x_lo[COORD_W-1:0];
    cmd_o.rect.y = y_lo[COORD_W-1:0];
    cmd_o.rect.w = COORD_W'(x_hi - x_lo);
    cmd_o.rect.h = COORD_W'(y_hi - y_lo);
    unique case (action_e'(req.action))
      ACT_ADD:        cmd_o.op = keep ? CMD_APPEND : CMD_REPORT;
      ACT_DAMAGE_ALL: begin
        cmd_o.op = CMD_SET;
        cmd_o.rect = '{x: '0, y: '0, w: screen_w_i, h: screen_h_i};
      end
      ACT_MERGE:      cmd_o.op = CMD_MERGE;
      ACT_DRAIN:      cmd_o.op = CMD_DRAIN;
      default:        cmd_o.op = CMD_REPORT;
    endcase
  end

endmodule

// ----- design/drt_queue.sv -----
module drt_queue import drt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o = slot_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- design/drt_back.sv -----
module drt_back import drt_pkg::*; #(
  parameter int unsigned MAX_RECTS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  cmd_t                         q_cmd_i,
  output logic                         q_pop_o,
  output logic                         we_o,
  output logic [$clog2(MAX_RECTS)-1:0] waddr_o,
  output rect_t                        wdata_o,
  output logic                         re_o,
  output logic [$clog2(MAX_RECTS)-1:0] raddr_o,
  input  rect_t                        rdata_i,
  drt_chan_if.source                   out_o
);

  localparam int unsigned IW = $clog2(MAX_RECTS);
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECTS);

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } box_t;

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  rect_t       a_q, a_d, res_q, res_d;
  box_t        bb_q, bb_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        out_free;

  // corners of a stored rectangle
  function automatic box_t to_box(rect_t r);
    box_t b;
    b.x0 = {1'b0, r.x};
    b.y0 = {1'b0, r.y};
    b.x1 = {1'b0, r.x} + {1'b0, r.w};
    b.y1 = {1'b0, r.y} + {1'b0, r.h};
    return b;
  endfunction

  function automatic box_t join_box(box_t a, box_t b);
    box_t r;
    r.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
    r.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
    r.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    r.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    return r;
  endfunction

  function automatic rect_t to_rect(box_t b);
    rect_t r;
    r.x = b.x0[COORD_W-1:0];
    r.y = b.y0[COORD_W-1:0];
    r.w = COORD_W'(b.x1 - b.x0);
    r.h = COORD_W'(b.y1 - b.y0);
    return r;
  endfunction

  // a grown by one pixel on every side overlaps b
  function automatic logic grown_hit(rect_t a, rect_t b);
    logic signed [17:0] gx0, gy0, gx1, gy1, bx0, by0, bx1, by1, lx, ly, hx, hy;
    gx0 = 18'(a.x) - 18'sd1;
    gy0 = 18'(a.y) - 18'sd1;
    gx1 = 18'(a.x) + 18'(a.w) + 18'sd1;
    gy1 = 18'(a.y) + 18'(a.h) + 18'sd1;
    bx0 = 18'(b.x);
    by0 = 18'(b.y);
    bx1 = 18'(b.x) + 18'(b.w);
    by1 = 18'(b.y) + 18'(b.h);
    lx = (gx0 > bx0) ? gx0 : bx0;
    ly = (gy0 > by0) ? gy0 : by0;
    hx = (gx1 < bx1) ? gx1 : bx1;
    hy = (gy1 < by1) ? gy1 : by1;
    return (hx > lx) && (hy > ly);
  endfunction

  assign out_free = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // sequencer for list walks
  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    i_d = i_q;
    j_d = j_q;
    a_d = a_q;
    res_d = res_q;
    bb_d = bb_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    q_pop_o = 1'b0;
    we_o = 1'b0;
    waddr_o = '0;
    wdata_o = cmd_q.rect;
    re_o = 1'b0;
    raddr_o = '0;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d = q_cmd_i;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        i_d = '0;
        unique case (cmd_q.op)
          CMD_REPORT: state_d = B_EMIT;
          CMD_SET: begin
            we_o = 1'b1;
            cnt_d = CW'(1);
            state_d = B_EMIT;
          end
          CMD_APPEND: begin
            if (cnt_q < CNT_MAX) begin
              we_o = 1'b1;
              waddr_o = cnt_q[IW-1:0];
              cnt_d = cnt_q + 1'b1;
              state_d = B_EMIT;
            end else begin
              bb_d = to_box(cmd_q.rect);
              state_d = B_COL_RD;
            end
          end
          CMD_MERGE: state_d = (cnt_q < CW'(2)) ? B_EMIT : B_M_RDI;
          CMD_DRAIN: state_d = (cnt_q == '0) ? B_EMIT : B_D_RD;
          default:   state_d = B_EMIT;
        endcase
      end
      // collapse a full list into one bounding box
      B_COL_RD: begin
        re_o = 1'b1;
        raddr_o = i_q[IW-1:0];
        state_d = B_COL_ACC;
      end
      B_COL_ACC: begin
        bb_d = join_box(bb_q, to_box(rdata_i));
        i_d = i_q + 1'b1;
        state_d = (i_d == cnt_q) ? B_COL_WR : B_COL_RD;
      end
      B_COL_WR: begin
        we_o = 1'b1;
        wdata_o = to_rect(bb_q);
        cnt_d = CW'(1);
        state_d = B_EMIT;
      end
      // pairwise merge search
      B_M_RDI: begin
        re_o = 1'b1;
        raddr_o = i_q[IW-1:0];
        state_d = B_M_LDI;
      end
      B_M_LDI: begin
        a_d = rdata_i;
        j_d = i_q + 1'b1;
        state_d = B_M_RDJ;
      end
      B_M_RDJ: begin
        re_o = 1'b1;
        raddr_o = j_q[IW-1:0];
        state_d = B_M_TST;
      end
      B_M_TST: begin
        if (grown_hit(a_q, rdata_i)) begin
          res_d = to_rect(join_box(to_box(a_q), to_box(rdata_i)));
          state_d = B_M_WI;
        end else if (j_q + 1'b1 < cnt_q) begin
          j_d = j_q + 1'b1;
          state_d = B_M_RDJ;
        end else if (i_q + CW'(2) < cnt_q) begin
          i_d = i_q + 1'b1;
          state_d = B_M_RDI;
        end else begin
          state_d = B_EMIT;
        end
      end
      B_M_WI: begin
        we_o = 1'b1;
        waddr_o = i_q[IW-1:0];
        wdata_o = res_q;
        re_o = 1'b1;
        raddr_o = IW'(cnt_q - 1'b1);
        state_d = B_M_WJ;
      end
      B_M_WJ: begin
        we_o = 1'b1;
        waddr_o = j_q[IW-1:0];
        wdata_o = rdata_i;
        cnt_d = cnt_q - 1'b1;
        i_d = '0;
        state_d = (cnt_d > CW'(1)) ? B_M_RDI : B_EMIT;
      end
      // drain walk
      B_D_RD: begin
        re_o = 1'b1;
        raddr_o = i_q[IW-1:0];
        state_d = B_D_OUT;
      end
      B_D_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{out_x: rdata_i.x, out_y: rdata_i.y, out_w: rdata_i.w,
                    out_h: rdata_i.h, rect_valid: 1'b1,
                    last: (i_q + 1'b1 == cnt_q), list_count: '0};
          if (i_q + 1'b1 == cnt_q) begin
            cnt_d = '0;
            state_d = B_IDLE;
          end else begin
            i_d = i_q + 1'b1;
            state_d = B_D_RD;
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{out_x: '0, out_y: '0, out_w: '0, out_h: '0, rect_valid: 1'b0,
                    last: 1'b1, list_count: LIST_CNT_W'(cnt_q)};
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    i_q <= i_d;
    j_q <= j_d;
    a_q <= a_d;
    res_q <= res_d;
    bb_q <= bb_d;
    out_q <= out_d;
  end

endmodule

// ----- design/dirty_rect_tracker.sv -----
// dirty rectangle tracker: keeps a bounded list of damaged screen areas
// in_i carries requests (action, rect_x/y/w/h); an add clips to the screen,
// damage-all sets the full screen, merge joins touching entries, drain
// emits the list on out_o and empties it
// out_o gives one result per request (rect_valid 0, last 1, list_count),
// or for a drain one result per entry with rect_valid 1 and last on the final
// the APB port holds screen width (address 0) and height (address 4)
// the front end classifies a request in the cycle it is taken and puts it in
// a two-deep queue; the back end works through it on a list ram with one
// read port and one write port
// an add with room or a damage-all is written in B_EXEC, reported in B_EMIT;
// the back end takes the next request only once back in B_IDLE; a drain reads
// then outputs each entry; a merge loads each new first entry, reads and tests
// each pair, writes each join and starts over until no pair joins; collapsing
// a full list reads and joins each entry, all through the single ram read port
// reset empties the list and loads width 1024 and height 768
// a stalled receiver holds the result register; the back end then waits and
// the queue takes up to two more requests before in_i drops ready
module dirty_rect_tracker import drt_pkg::*; #(
  parameter int unsigned MAX_RECTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drt_chan_if.sink    in_i,
  drt_chan_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(MAX_RECTS);

  logic [COORD_W-1:0] width_q, height_q;
  logic               push, full, q_valid, q_pop, we, re;
  cmd_t               push_cmd, q_cmd;
  logic [IW-1:0]      waddr, raddr;
  rect_t              wdata, rdata;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HEIGHT) height_q <= pwdata[COORD_W-1:0];
      else width_q <= pwdata[COORD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      prdata = (paddr[2] == REG_WIDTH) ? 32'(width_q) : 32'(height_q);
    end
  end

  drt_front u_front (
    .in_i       (in_i),
    .screen_w_i (width_q),
    .screen_h_i (height_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  drt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  drt_back #(
    .MAX_RECTS (MAX_RECTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .re_o      (re),
    .raddr_o   (raddr),
    .rdata_i   (rdata),
    .out_o     (out_o)
  );

  drt_ram #(
    .WIDTH ($bits(rect_t)),
    .DEPTH (MAX_RECTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
